// ===== rtl/als_pkg.sv =====
// Package for the array list: widths, command and status codes, cell control type.
package als_pkg;

  localparam int unsigned Depth  = 16;
  localparam int unsigned DataW  = 32;
  localparam int unsigned CmdW   = 3;
  localparam int unsigned PosW   = 4;
  localparam int unsigned StatW  = 2;
  localparam int unsigned CountW = 5;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned IdxW   = (Depth > 1) ? $clog2(Depth) : 1;
  // compare width that holds both a position and a count
  localparam int unsigned AtW    = (CntW > PosW) ? CntW : PosW;

  typedef enum logic [CmdW-1:0] {
    CMD_INS_TAIL = 3'd0,
    CMD_INS_HEAD = 3'd1,
    CMD_INS_AT   = 3'd2,
    CMD_RM_TAIL  = 3'd3,
    CMD_RM_HEAD  = 3'd4,
    CMD_RM_AT    = 3'd5
  } cmd_e;

  typedef enum logic [StatW-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  // broadcast to every cell: qualified shift request
  typedef struct packed {
    logic           ins;
    logic           rm;
    logic [AtW-1:0] at;
    logic [AtW-1:0] count;
  } shift_t;

endpackage

// ===== rtl/als_cell.sv =====
// One list entry: holds its value, loads, or takes a neighbor's value on a shift.
module als_cell (
  input  logic                              clk_i,
  input  als_pkg::shift_t                   ctrl_i,
  input  logic [als_pkg::AtW-1:0]           idx_i,
  input  logic signed [als_pkg::DataW-1:0]  value_i,
  input  logic signed [als_pkg::DataW-1:0]  prev_i,
  input  logic signed [als_pkg::DataW-1:0]  next_i,
  output logic signed [als_pkg::DataW-1:0]  data_o
);
  import als_pkg::*;

  logic signed [DataW-1:0] data_q, data_d;
  logic [AtW-1:0]          idx_inc;

  assign idx_inc = idx_i + AtW'(1);

  always_comb begin
    data_d = data_q;
    if (ctrl_i.ins) begin
      if (idx_i == ctrl_i.at) begin
        data_d = value_i;
      end else if (idx_i > ctrl_i.at && idx_i <= ctrl_i.count) begin
        data_d = prev_i;
      end
    end else if (ctrl_i.rm) begin
      // close the gap: pull from the right up to the old tail
      if (idx_i >= ctrl_i.at && idx_inc < ctrl_i.count) begin
        data_d = next_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;

endmodule

// ===== rtl/array_list_shift_insert_remove.sv =====
// Top level of the array list: command decode, count, row of entry cells, result register.
//
// Ordered list of signed 32-bit values in a row of 16 entry cells, entry 0 at the
// head. Each transaction on the input channel carries one command (insert at
// tail, head or position; remove from tail, head or position) and produces
// exactly one transaction on the output channel with the removed value (0 for
// inserts and failures), a status (ok, full, empty, position out of range) and
// the count after the command. A rejected command leaves the list unchanged;
// commands 6 and 7 answer ok with the count unchanged. All cells shift in
// parallel on the accepting edge, so one command completes per clock cycle:
// the result is registered and visible the cycle after acceptance, and the next
// command is taken in that same cycle whenever the result register is empty or
// is being drained. Throughput is therefore set only by the single output
// register and out_ready_i. No clearing pass is needed after reset; entries at
// or beyond the count are never read.
module array_list_shift_insert_remove (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [als_pkg::CmdW-1:0]              command_i,
  input  logic signed [als_pkg::DataW-1:0]      value_i,
  input  logic [als_pkg::PosW-1:0]              position_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [als_pkg::DataW-1:0]      removed_value_o,
  output logic [als_pkg::StatW-1:0]             status_o,
  output logic [als_pkg::CountW-1:0]            count_o
);
  import als_pkg::*;

  logic                    accept;
  logic [CntW-1:0]         count_q, count_d;
  logic [AtW-1:0]          count_ext;
  logic [AtW-1:0]          at;
  logic                    is_ins, is_rm;
  status_e                 status;
  logic signed [DataW-1:0] removed;
  shift_t                  shift;
  logic signed [DataW-1:0] cell_data [Depth];

  logic                    out_valid_q;
  logic signed [DataW-1:0] removed_q;
  status_e                 status_q;
  logic [CountW-1:0]       count_out_q;

  // take a new command whenever the result slot is free or draining
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign count_ext  = AtW'(count_q);

  // decode the command into a target place and a kind
  always_comb begin
    is_ins = 1'b0;
    is_rm  = 1'b0;
    at     = '0;
    unique case (command_i)
      CMD_INS_TAIL: begin is_ins = 1'b1; at = count_ext; end
      CMD_INS_HEAD: begin is_ins = 1'b1; at = '0; end
      CMD_INS_AT:   begin is_ins = 1'b1; at = AtW'(position_i); end
      CMD_RM_TAIL:  begin is_rm = 1'b1;  at = count_ext - AtW'(1); end
      CMD_RM_HEAD:  begin is_rm = 1'b1;  at = '0; end
      CMD_RM_AT:    begin is_rm = 1'b1;  at = AtW'(position_i); end
      default:      begin is_ins = 1'b0; is_rm = 1'b0; at = '0; end
    endcase
  end

  // check full / empty first, then the position; pick the removed entry
  always_comb begin
    status    = ST_OK;
    removed   = '0;
    count_d   = count_q;
    shift.ins = 1'b0;
    shift.rm  = 1'b0;
    shift.at  = at;
    shift.count = count_ext;
    if (is_ins) begin
      if (count_q == CntW'(Depth)) begin
        status = ST_FULL;
      end else if (at > count_ext) begin
        status = ST_RANGE;
      end else begin
        shift.ins = accept;
        count_d   = count_q + CntW'(1);
      end
    end else if (is_rm) begin
      if (count_q == '0) begin
        status = ST_EMPTY;
      end else if (at >= count_ext) begin
        status = ST_RANGE;
      end else begin
        shift.rm = accept;
        removed  = cell_data[at[IdxW-1:0]];
        count_d  = count_q - CntW'(1);
      end
    end
  end

  // row of entry cells; the head cell takes value_i as its left neighbor, the tail cell its own value as its right
  for (genvar i = 0; i < Depth; i++) begin : g_cell
    logic signed [DataW-1:0] prev_w, next_w;
    if (i == 0) begin : g_head
      assign prev_w = value_i;
    end else begin : g_mid_prev
      assign prev_w = cell_data[i-1];
    end
    if (i == Depth - 1) begin : g_tail
      assign next_w = cell_data[i];
    end else begin : g_mid_next
      assign next_w = cell_data[i+1];
    end
    als_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (shift),
      .idx_i   (AtW'(i)),
      .value_i (value_i),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .data_o  (cell_data[i])
    );
  end

  // advance the count and the valid flag of the result slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // hold the result payload until taken
  always_ff @(posedge clk_i) begin
    if (accept) begin
      removed_q   <= removed;
      status_q    <= status;
      count_out_q <= CountW'(count_d);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign removed_value_o = removed_q;
  assign status_o        = status_q;
  assign count_o         = count_out_q;

endmodule

// ===== bench/als_list_checker.sv =====
// Checker for the array list: tracks the list contents, predicts each answer and compares.
`timescale 1ns / 1ps

module als_list_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  input  logic                              in_ready_i,
  input  logic [als_pkg::CmdW-1:0]          command_i,
  input  logic signed [als_pkg::DataW-1:0]  value_i,
  input  logic [als_pkg::PosW-1:0]          position_i,
  input  logic                              out_valid_i,
  input  logic                              out_ready_i,
  input  logic signed [als_pkg::DataW-1:0]  removed_value_i,
  input  logic [als_pkg::StatW-1:0]         status_i,
  input  logic [als_pkg::CountW-1:0]        count_i,
  output int                                outstanding_o,
  output int                                fail_count_o
);
  import als_pkg::*;

  typedef struct packed {
    logic signed [DataW-1:0] removed;
    status_e                 status;
    logic [CountW-1:0]       count;
  } answer_t;

  logic signed [DataW-1:0] list_q [Depth];
  int unsigned             list_len;
  answer_t                 answers_q[$];
  int                      fails;

  initial begin
    list_len = 0;
    fails    = 0;
  end

  // Apply one list command to the shadow list and return the answer it gives.
  function automatic answer_t apply_command(logic [CmdW-1:0] cmd,
                                            logic signed [DataW-1:0] val,
                                            logic [PosW-1:0] pos);
    answer_t     ans;
    int unsigned at;
    ans.removed = '0;
    ans.status  = ST_OK;
    unique case (cmd)
      CMD_INS_TAIL, CMD_INS_HEAD, CMD_INS_AT: begin
        at = (cmd == CMD_INS_TAIL) ? list_len : (cmd == CMD_INS_HEAD) ? 0 : pos;
        if (list_len >= Depth) begin
          ans.status = ST_FULL;
        end else if (at > list_len) begin
          ans.status = ST_RANGE;
        end else begin
          for (int i = list_len; i > at; i--) list_q[i] = list_q[i-1];
          list_q[at] = val;
          list_len++;
        end
      end
      CMD_RM_TAIL, CMD_RM_HEAD, CMD_RM_AT: begin
        if (list_len == 0) begin
          ans.status = ST_EMPTY;
        end else begin
          at = (cmd == CMD_RM_TAIL) ? list_len - 1 : (cmd == CMD_RM_HEAD) ? 0 : pos;
          if (at >= list_len) begin
            ans.status = ST_RANGE;
          end else begin
            ans.removed = list_q[at];
            for (int i = at; i + 1 < list_len; i++) list_q[i] = list_q[i+1];
            list_len--;
          end
        end
      end
      default: ;
    endcase
    ans.count = CountW'(list_len);
    return ans;
  endfunction

  always @(posedge clk_i) begin
    answer_t want;
    if (!rst_ni) begin
      list_len = 0;
      answers_q.delete();
    end else begin
      // Check the result first: it always belongs to an older command.
      if (out_valid_i && out_ready_i) begin
        if (answers_q.size() == 0) begin
          $error("result transaction with no command waiting");
          fails++;
        end else begin
          want = answers_q.pop_front();
          if (removed_value_i !== want.removed) begin
            $error("removed_value: expected %0d, got %0d", want.removed, removed_value_i);
            fails++;
          end
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            fails++;
          end
          if (count_i !== want.count) begin
            $error("count: expected %0d, got %0d", want.count, count_i);
            fails++;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        answers_q.push_back(apply_command(command_i, value_i, position_i));
      end
    end
    outstanding_o <= answers_q.size();
    fail_count_o  <= fails;
  end

endmodule

// ===== bench/tb_array_list_shift_insert_remove.sv =====
// Testbench top for the array list: clock, reset, command stimulus, result drain and verdict.
`timescale 1ns / 1ps

module tb_array_list_shift_insert_remove;
  import als_pkg::*;

  // Command codes the block answers without touching the list.
  localparam logic [CmdW-1:0]         CmdSpareA = 3'd6;
  localparam logic [CmdW-1:0]         CmdSpareB = 3'd7;
  localparam logic signed [DataW-1:0] MaxVal    = 32'sh7FFF_FFFF;
  localparam logic signed [DataW-1:0] MinVal    = 32'sh8000_0000;
  localparam int                      NumRandom = 1500;
  localparam int                      CycleCap  = 200000;

  // Random bursts lean toward filling, draining or a mix, so the list
  // regularly reaches both full and empty.
  typedef enum int {
    MOOD_FILL,
    MOOD_DRAIN,
    MOOD_MIX
  } mood_e;

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    in_valid_i  = 1'b0;
  logic                    in_ready_o;
  logic [CmdW-1:0]         command_i   = '0;
  logic signed [DataW-1:0] value_i     = '0;
  logic [PosW-1:0]         position_i  = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic signed [DataW-1:0] removed_value_o;
  logic [StatW-1:0]        status_o;
  logic [CountW-1:0]       count_o;

  int   outstanding;
  int   fail_count;
  int   cycles = 0;
  int   fill   = 0;       // list length as the stimulus sees it, to aim positions
  logic steady = 1'b0;    // no idling on either side while high

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  array_list_shift_insert_remove dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .command_i,
    .value_i,
    .position_i,
    .out_valid_o,
    .out_ready_i,
    .removed_value_o,
    .status_o,
    .count_o
  );

  als_list_checker checker_i (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_i      (in_ready_o),
    .command_i,
    .value_i,
    .position_i,
    .out_valid_i     (out_valid_o),
    .out_ready_i,
    .removed_value_i (removed_value_o),
    .status_i        (status_o),
    .count_i         (count_o),
    .outstanding_o   (outstanding),
    .fail_count_o    (fail_count)
  );

  // Receiver: stall in about a quarter of the cycles, except in the steady window.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= steady || ($urandom_range(0, 99) >= 26);
    end
  end

  // Watchdog: end the run if the block stops moving.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleCap) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Track the list length the same way a user would, only to aim positions.
  function automatic int next_fill(int f, logic [CmdW-1:0] cmd, logic [PosW-1:0] pos);
    unique case (cmd)
      CMD_INS_TAIL, CMD_INS_HEAD: return (f < Depth) ? f + 1 : f;
      CMD_INS_AT:                 return (f < Depth && pos <= f) ? f + 1 : f;
      CMD_RM_TAIL, CMD_RM_HEAD:   return (f > 0) ? f - 1 : f;
      CMD_RM_AT:                  return (pos < f) ? f - 1 : f;
      default:                    return f;
    endcase
  endfunction

  function automatic logic [CmdW-1:0] pick_command(mood_e m);
    int ins_pct;
    ins_pct = (m == MOOD_FILL) ? 80 : (m == MOOD_DRAIN) ? 20 : 50;
    // A few spare codes mixed in as noise.
    if ($urandom_range(0, 99) < 3) return ($urandom_range(0, 1) != 0) ? CmdSpareA : CmdSpareB;
    if ($urandom_range(0, 99) < ins_pct) begin
      unique case ($urandom_range(0, 2))
        0:       return CMD_INS_TAIL;
        1:       return CMD_INS_HEAD;
        default: return CMD_INS_AT;
      endcase
    end
    unique case ($urandom_range(0, 2))
      0:       return CMD_RM_TAIL;
      1:       return CMD_RM_HEAD;
      default: return CMD_RM_AT;
    endcase
  endfunction

  function automatic logic signed [DataW-1:0] pick_value();
    unique case ($urandom_range(0, 15))
      0:       return MaxVal;
      1:       return MinVal;
      2:       return '0;
      3:       return -1;
      default: return $urandom;
    endcase
  endfunction

  // Mostly legal positions for the positional commands; the rest anywhere in the field.
  function automatic logic [PosW-1:0] pick_position(logic [CmdW-1:0] cmd, int f);
    if ($urandom_range(0, 99) < 85) begin
      if (cmd == CMD_INS_AT) return PosW'($urandom_range(0, (f > 15) ? 15 : f));
      if (cmd == CMD_RM_AT && f > 0) return PosW'($urandom_range(0, f - 1));
    end
    return PosW'($urandom_range(0, 15));
  endfunction

  // Present one command and hold it until the transaction completes.
  task automatic send_item(logic [CmdW-1:0] cmd, logic signed [DataW-1:0] val,
                           logic [PosW-1:0] pos, logic calm);
    while (!calm && $urandom_range(0, 99) < 26) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    command_i  <= cmd;
    value_i    <= val;
    position_i <= pos;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    fill = next_fill(fill, cmd, pos);
  endtask

  // Drop valid and wait until every answer has been drained.
  task automatic hold_until_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  initial begin
    mood_e           mood;
    logic [CmdW-1:0] cmd;
    logic            calm;

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty removes, spare codes, inserts at every place, range errors.
    send_item(CMD_RM_TAIL,  '0,     4'd0,  1'b0);
    send_item(CMD_RM_HEAD,  '0,     4'd0,  1'b0);
    send_item(CMD_RM_AT,    '0,     4'd0,  1'b0);
    send_item(CmdSpareA,    MaxVal, 4'd15, 1'b0);
    send_item(CMD_INS_AT,   '0,     4'd1,  1'b0);
    send_item(CMD_INS_TAIL, MaxVal, 4'd0,  1'b0);
    send_item(CMD_INS_HEAD, MinVal, 4'd15, 1'b0);
    send_item(CMD_INS_AT,   '0,     4'd2,  1'b0);
    send_item(CMD_INS_AT,   -1,     4'd1,  1'b0);
    send_item(CMD_INS_AT,   1,      4'd0,  1'b0);
    send_item(CMD_INS_AT,   42,     4'd15, 1'b0);
    send_item(CMD_RM_AT,    '0,     4'd5,  1'b0);
    send_item(CmdSpareB,    -1,     4'd7,  1'b0);
    send_item(CMD_RM_AT,    '0,     4'd2,  1'b0);
    send_item(CMD_RM_HEAD,  '0,     4'd0,  1'b0);
    send_item(CMD_RM_TAIL,  '0,     4'd0,  1'b0);
    send_item(CMD_RM_AT,    '0,     4'd0,  1'b0);
    send_item(CMD_RM_AT,    '0,     4'd0,  1'b0);
    hold_until_drained();

    // Random: bursts of 50 with a drift toward full, empty or neither.
    mood = MOOD_MIX;
    for (int n = 0; n < NumRandom; n++) begin
      if (n % 50 == 0) mood = mood_e'($urandom_range(0, 2));
      calm = (n >= 700 && n < 1000);
      if (n == 700 || n == 1000) steady <= calm;
      // Let the pipe run dry once in the middle of the random part.
      if (n == 400) hold_until_drained();
      cmd = pick_command(mood);
      send_item(cmd, pick_value(), pick_position(cmd, fill), calm);
    end

    hold_until_drained();
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
